// ===== hdl/dxt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dxt_pkg;

    typedef enum logic [1:0] {
        FMT_DXT1 = 2'd0,
        FMT_DXT3 = 2'd1,
        FMT_DXT5 = 2'd2,
        FMT_NONE = 2'd3
    } t_format;

    // One color block as the back end sees it, with the alpha half that went before it.
    typedef struct packed {
        t_format     mode;
        logic [63:0] alpha_word;
        logic [63:0] color_word;
    } t_cmd;

    typedef struct packed {
        logic [31:0] texel;
        logic [1:0]  row;
        logic [1:0]  col;
        logic        last;
    } t_texel_item;

    typedef struct packed {
        logic [2:0] w0;
        logic [2:0] w1;
        logic       force_max;
    } t_alpha_weights;

    localparam int CMD_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 4;

    localparam logic [3:0]  TEXEL_LAST    = 4'd15;
    localparam logic [8:0]  DIV3_MUL      = 9'd171;
    localparam logic [11:0] DIV7_MUL      = 12'd2341;
    localparam logic [11:0] DIV5_MUL      = 12'd3277;
    localparam logic [10:0] ALPHA_MAX_SUM = 11'd1275;

    // Three times the chosen palette entry of one channel, so every entry divides by 3.
    function automatic logic [7:0] color_sum(input logic [5:0] x0, input logic [5:0] x1,
                                             input logic [1:0] ci);
        logic [7:0] e0;
        logic [7:0] e1;
        logic [7:0] s;
        e0 = {2'b00, x0};
        e1 = {2'b00, x1};
        unique case (ci)
            2'd0: s = (e0 << 1) + e0;
            2'd1: s = (e1 << 1) + e1;
            2'd2: s = (e0 << 1) + e1;
            2'd3: s = e0 + (e1 << 1);
        endcase
        return s;
    endfunction

    // Weights of a0 and a1 for one alpha palette entry; the divisor is 7 when a0 > a1, else 5.
    function automatic t_alpha_weights alpha_weights(input logic gt, input logic [2:0] ai);
        t_alpha_weights w;
        w.force_max = 1'b0;
        if (gt) begin
            unique case (ai)
                3'd0: begin w.w0 = 3'd7; w.w1 = 3'd0; end
                3'd1: begin w.w0 = 3'd0; w.w1 = 3'd7; end
                3'd2: begin w.w0 = 3'd6; w.w1 = 3'd1; end
                3'd3: begin w.w0 = 3'd5; w.w1 = 3'd2; end
                3'd4: begin w.w0 = 3'd4; w.w1 = 3'd3; end
                3'd5: begin w.w0 = 3'd3; w.w1 = 3'd4; end
                3'd6: begin w.w0 = 3'd2; w.w1 = 3'd5; end
                3'd7: begin w.w0 = 3'd1; w.w1 = 3'd6; end
            endcase
        end else begin
            unique case (ai)
                3'd0: begin w.w0 = 3'd5; w.w1 = 3'd0; end
                3'd1: begin w.w0 = 3'd0; w.w1 = 3'd5; end
                3'd2: begin w.w0 = 3'd4; w.w1 = 3'd1; end
                3'd3: begin w.w0 = 3'd3; w.w1 = 3'd2; end
                3'd4: begin w.w0 = 3'd2; w.w1 = 3'd3; end
                3'd5: begin w.w0 = 3'd1; w.w1 = 3'd4; end
                3'd6: begin w.w0 = 3'd0; w.w1 = 3'd0; end
                3'd7: begin w.w0 = 3'd0; w.w1 = 3'd0; w.force_max = 1'b1; end
            endcase
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dxt_block_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// block in  input      push / full        i_block_word
// texel out output     empty / pop        o_texel, o_texel_row, o_texel_col, o_last_texel
// config    input      i_cfg_we           i_cfg_wdata (format_mode)
//
// A color half yields 16 texels, one per cycle while the output queue has room,
// issued by the back end's texel counter.
// An alpha half is held in the front end and yields nothing.
// A texel passes from the command queue through the back end's stage-one registers into the output queue.
// The command queue lets the front take the next words while a block is being decoded.
// Reset is synchronous and clears the format, the pairing flag and both queues.

module dxt_block_decoder #(
    parameter int CMD_DEPTH = dxt_pkg::CMD_DEPTH_DEF,
    parameter int OUT_DEPTH = dxt_pkg::OUT_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic [63:0]    i_block_word,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_wdata,
    output logic                empty,
    input  wire logic           pop,
    output logic [31:0]         o_texel,
    output logic [1:0]          o_texel_row,
    output logic [1:0]          o_texel_col,
    output logic                o_last_texel
);

    dxt_pkg::t_cmd        front_cmd;
    logic                 front_push;
    logic                 cmd_full;
    logic                 cmd_empty;
    dxt_pkg::t_cmd        head_cmd;
    logic                 cmd_pop;
    logic                 out_push;
    dxt_pkg::t_texel_item out_item;
    dxt_pkg::t_texel_item head_item;
    logic                 out_full;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
    logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

    dxt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_block_word (i_block_word),
        .o_full       (full),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd_full   (cmd_full),
        .o_cmd_push   (front_push),
        .o_cmd        (front_cmd)
    );

    dxt_queue #(
        .WIDTH ($bits(dxt_pkg::t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (head_cmd),
        .o_empty (cmd_empty),
        .o_count (cmd_count)
    );

    dxt_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out_data  (out_item)
    );

    dxt_queue #(
        .WIDTH ($bits(dxt_pkg::t_texel_item)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_item),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (head_item),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_texel      = head_item.texel;
    assign o_texel_row  = head_item.row;
    assign o_texel_col  = head_item.col;
    assign o_last_texel = head_item.last;

    a_cmd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> (cmd_count != '0))
        else $error("block request popped from an empty command queue");

endmodule

`default_nettype wire

// ===== hdl/dxt_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dxt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dxt_pkg::CMD_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    output logic                            o_full,
    input  wire logic                       i_pop,
    output logic [WIDTH-1:0]                o_data,
    output logic                            o_empty,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dxt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dxt_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire logic [63:0]    i_block_word,
    output logic                o_full,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_wdata,
    input  wire logic           i_cmd_full,
    output logic                o_cmd_push,
    output dxt_pkg::t_cmd       o_cmd
);

    dxt_pkg::t_format r_format_mode, n_format_mode;
    logic             r_awaiting, n_awaiting;
    logic [63:0]      r_alpha_word, n_alpha_word;
    logic             accept;

    assign o_full = i_cmd_full;
    assign accept = i_push && !i_cmd_full;

    assign o_cmd.mode       = r_format_mode;
    assign o_cmd.alpha_word = r_alpha_word;
    assign o_cmd.color_word = i_block_word;

    always_comb begin
        n_format_mode = r_format_mode;
        n_awaiting    = r_awaiting;
        n_alpha_word  = r_alpha_word;
        o_cmd_push    = 1'b0;
        unique case (r_format_mode)
            dxt_pkg::FMT_DXT1: begin
                o_cmd_push = accept;
            end
            dxt_pkg::FMT_DXT3, dxt_pkg::FMT_DXT5: begin
                if (accept) begin
                    if (r_awaiting) begin
                        o_cmd_push = 1'b1;
                        n_awaiting = 1'b0;
                    end else begin
                        n_alpha_word = i_block_word;
                        n_awaiting   = 1'b1;
                    end
                end
            end
            dxt_pkg::FMT_NONE: begin
                o_cmd_push = 1'b0;
            end
        endcase
        // A format write restarts the pairing, so in DXT3 or DXT5 the next word is an alpha half.
        if (i_cfg_we) begin
            n_format_mode = dxt_pkg::t_format'(i_cfg_wdata);
            n_awaiting    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_mode <= dxt_pkg::FMT_DXT1;
            r_awaiting    <= 1'b0;
        end else begin
            r_format_mode <= n_format_mode;
            r_awaiting    <= n_awaiting;
        end
    end

    always_ff @(posedge i_clk) begin
        r_alpha_word <= n_alpha_word;
    end

    a_await_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awaiting |-> (r_format_mode == dxt_pkg::FMT_DXT3 ||
                        r_format_mode == dxt_pkg::FMT_DXT5))
        else $error("alpha half held in a format without alpha");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !r_awaiting)
        else $error("format write did not restart block pairing");

endmodule

`default_nettype wire

// ===== hdl/dxt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dxt_back #(
    parameter int OUT_DEPTH = dxt_pkg::OUT_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cmd_valid,
    input  wire dxt_pkg::t_cmd                  i_cmd,
    output logic                                o_cmd_pop,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    input  wire logic                           i_out_full,
    output logic                                o_out_push,
    output dxt_pkg::t_texel_item                o_out_data
);

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic [3:0]  r_tex_idx, n_tex_idx;
    logic        room;
    logic        issue;

    // Stage one: palette sums for the texel being issued.
    logic [31:0] color_idx_bits;
    logic [47:0] alpha_idx_bits;
    logic [1:0]  ci;
    logic [2:0]  ai;
    logic [5:0]  a_off;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic        a_gt;
    dxt_pkg::t_alpha_weights aw;
    logic [10:0] n_asum;

    logic              r_s1_valid;
    dxt_pkg::t_format  r_s1_mode;
    logic [3:0]        r_s1_idx;
    logic [7:0]        r_s1_sum_r;
    logic [7:0]        r_s1_sum_g;
    logic [7:0]        r_s1_sum_b;
    logic [10:0]       r_s1_asum;
    logic              r_s1_div7;
    logic [3:0]        r_s1_a4;

    // Stage two: divide by constants and pack the texel.
    logic [16:0] q_r;
    logic [16:0] q_g;
    logic [16:0] q_b;
    logic [22:0] q_a;
    logic [23:0] rgb;

    assign room  = ({1'b0, i_out_count} + (CNT_W + 1)'(r_s1_valid)) < (CNT_W + 1)'(OUT_DEPTH);
    assign issue = i_cmd_valid && room;
    assign o_cmd_pop = issue && (r_tex_idx == dxt_pkg::TEXEL_LAST);
    assign n_tex_idx = issue ? r_tex_idx + 1'b1 : r_tex_idx;

    assign color_idx_bits = i_cmd.color_word[63:32];
    assign alpha_idx_bits = i_cmd.alpha_word[63:16];
    assign ci    = color_idx_bits[{r_tex_idx, 1'b0} +: 2];
    assign a_off = {2'b00, r_tex_idx} + {1'b0, r_tex_idx, 1'b0};
    assign ai    = alpha_idx_bits[a_off +: 3];
    assign a0    = i_cmd.alpha_word[7:0];
    assign a1    = i_cmd.alpha_word[15:8];
    assign a_gt  = a0 > a1;
    assign aw    = dxt_pkg::alpha_weights(a_gt, ai);
    assign n_asum = aw.force_max ? dxt_pkg::ALPHA_MAX_SUM
                                 : (11'(aw.w0) * 11'(a0)) + (11'(aw.w1) * 11'(a1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_idx  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_tex_idx  <= n_tex_idx;
            r_s1_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_mode  <= i_cmd.mode;
            r_s1_idx   <= r_tex_idx;
            r_s1_sum_r <= dxt_pkg::color_sum({1'b0, i_cmd.color_word[15:11]},
                                             {1'b0, i_cmd.color_word[31:27]}, ci);
            r_s1_sum_g <= dxt_pkg::color_sum(i_cmd.color_word[10:5],
                                             i_cmd.color_word[26:21], ci);
            r_s1_sum_b <= dxt_pkg::color_sum({1'b0, i_cmd.color_word[4:0]},
                                             {1'b0, i_cmd.color_word[20:16]}, ci);
            r_s1_asum  <= n_asum;
            r_s1_div7  <= a_gt;
            r_s1_a4    <= i_cmd.alpha_word[{r_tex_idx, 2'b00} +: 4];
        end
    end

    // x/3 for x < 512 is (x*171)>>9; x/7 and x/5 below 2048 use a 14-bit shift.
    assign q_r = 17'(r_s1_sum_r) * 17'(dxt_pkg::DIV3_MUL);
    assign q_g = 17'(r_s1_sum_g) * 17'(dxt_pkg::DIV3_MUL);
    assign q_b = 17'(r_s1_sum_b) * 17'(dxt_pkg::DIV3_MUL);
    assign q_a = 23'(r_s1_asum) * 23'(r_s1_div7 ? dxt_pkg::DIV7_MUL : dxt_pkg::DIV5_MUL);

    assign rgb = {q_r[13:9], 3'b000, q_g[14:9], 2'b00, q_b[13:9], 3'b000};

    always_comb begin
        o_out_push      = r_s1_valid;
        o_out_data.row  = r_s1_idx[3:2];
        o_out_data.col  = r_s1_idx[1:0];
        o_out_data.last = (r_s1_idx == dxt_pkg::TEXEL_LAST);
        unique case (r_s1_mode)
            dxt_pkg::FMT_DXT1: o_out_data.texel = {16'h0000, q_r[13:9], q_g[14:9], q_b[13:9]};
            dxt_pkg::FMT_DXT3: o_out_data.texel = {r_s1_a4, 4'h0, rgb};
            dxt_pkg::FMT_DXT5: o_out_data.texel = {q_a[21:14], rgb};
            default:           o_out_data.texel = '0;
        endcase
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !i_out_full)
        else $error("texel reached a full output queue");

    a_idx_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_tex_idx == '0))
        else $error("texel counter did not wrap at end of block");

    a_block_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tex_idx != '0) |-> i_cmd_valid)
        else $error("block left the queue before all texels were issued");

endmodule

`default_nettype wire

// ===== tb/sv/tb_dxt_block_decoder.sv =====
`timescale 1ns / 1ps

module tb_dxt_block_decoder;
    import dxt_pkg::*;

    localparam int RANDOM_ITEMS  = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 32;
    localparam int QUIET_LIMIT   = 5000;
    localparam int TEXELS        = 16;

    // Predicts the texels of each block and holds them until the decoder delivers them.
    class texel_scoreboard;
        t_format     mode;
        bit          color_next;
        logic [63:0] alpha_held;
        t_texel_item texel_q[$];
        int          errors;
        int          seen;

        function new();
            mode       = FMT_DXT1;
            color_next = 1'b0;
            alpha_held = '0;
            errors     = 0;
            seen       = 0;
        endfunction

        // Any format write also drops a half-finished alpha/color pair.
        function void set_format(t_format m);
            mode       = m;
            color_next = 1'b0;
        endfunction

        function int pending();
            return texel_q.size();
        endfunction

        function logic [15:0] palette_entry(logic [15:0] c0, logic [15:0] c1, logic [1:0] ci);
            int r0, g0, b0, r1, g1, b1, r, g, b;
            r0 = c0[15:11]; g0 = c0[10:5]; b0 = c0[4:0];
            r1 = c1[15:11]; g1 = c1[10:5]; b1 = c1[4:0];
            case (ci)
                2'd0: begin r = r0; g = g0; b = b0; end
                2'd1: begin r = r1; g = g1; b = b1; end
                2'd2: begin
                    r = (2 * r0 + r1) / 3;
                    g = (2 * g0 + g1) / 3;
                    b = (2 * b0 + b1) / 3;
                end
                default: begin
                    r = (r0 + 2 * r1) / 3;
                    g = (g0 + 2 * g1) / 3;
                    b = (b0 + 2 * b1) / 3;
                end
            endcase
            return {5'(r), 6'(g), 5'(b)};
        endfunction

        function logic [7:0] alpha_entry(logic [7:0] a0, logic [7:0] a1, logic [2:0] ai);
            int x0, x1, k;
            x0 = a0;
            x1 = a1;
            k  = ai;
            if (k == 0) return a0;
            if (k == 1) return a1;
            if (x0 > x1) return 8'(((8 - k) * x0 + (k - 1) * x1) / 7);
            if (k < 6) return 8'(((6 - k) * x0 + (k - 1) * x1) / 5);
            if (k == 6) return 8'h00;
            return 8'hFF;
        endfunction

        function void note_word(logic [63:0] w);
            t_texel_item item;
            logic [15:0] c;
            if (mode == FMT_NONE) return;
            if (mode != FMT_DXT1 && !color_next) begin
                alpha_held = w;
                color_next = 1'b1;
                return;
            end
            color_next = 1'b0;
            for (int t = 0; t < TEXELS; t++) begin
                c = palette_entry(w[15:0], w[31:16], w[32 + 2 * t +: 2]);
                if (mode == FMT_DXT1) begin
                    item.texel = {16'h0000, c};
                end else begin
                    item.texel = {8'h00, c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
                    if (mode == FMT_DXT3)
                        item.texel[31:28] = alpha_held[4 * t +: 4];
                    else
                        item.texel[31:24] = alpha_entry(alpha_held[7:0], alpha_held[15:8],
                                                        alpha_held[16 + 3 * t +: 3]);
                end
                item.row  = 2'(t >> 2);
                item.col  = 2'(t & 3);
                item.last = (t == TEXELS - 1);
                texel_q.push_back(item);
            end
        endfunction

        task report(string what);
            $display("MISMATCH texel %0d: %s", seen, what);
            errors++;
        endtask

        task check_texel(t_texel_item got);
            t_texel_item exp;
            if (texel_q.size() == 0) begin
                report($sformatf("unexpected texel %h", got.texel));
                seen++;
                return;
            end
            exp = texel_q.pop_front();
            if (got.texel !== exp.texel)
                report($sformatf("texel %h, expected %h", got.texel, exp.texel));
            if (got.row !== exp.row)
                report($sformatf("row %0d, expected %0d", got.row, exp.row));
            if (got.col !== exp.col)
                report($sformatf("col %0d, expected %0d", got.col, exp.col));
            if (got.last !== exp.last)
                report($sformatf("last %b, expected %b", got.last, exp.last));
            seen++;
        endtask
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic [63:0] i_block_word = '0;
    logic        i_cfg_we     = 1'b0;
    logic [1:0]  i_cfg_wdata  = '0;
    logic        pop          = 1'b0;
    logic        full;
    logic        empty;
    logic [31:0] o_texel;
    logic [1:0]  o_texel_row;
    logic [1:0]  o_texel_col;
    logic        o_last_texel;

    texel_scoreboard sb;
    int          burst_left   = 1;
    int          quiet_cycles = 0;
    logic [31:0] rx_cycle     = '0;

    dxt_block_decoder DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_block_word (i_block_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .empty        (empty),
        .pop          (pop),
        .o_texel      (o_texel),
        .o_texel_row  (o_texel_row),
        .o_texel_col  (o_texel_col),
        .o_last_texel (o_last_texel)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver's duty cycle steps with rx_cycle[9:6]: eight fixed patterns, then eight random ones.
    always @(posedge i_clk) begin : rx_proc
        logic [3:0] epoch;
        logic       want;
        if (pop && !empty)
            sb.check_texel({o_texel, o_texel_row, o_texel_col, o_last_texel});
        epoch = rx_cycle[9:6];
        if (epoch[3])
            want = ($urandom_range(0, 7) <= epoch[2:0]);
        else
            want = (rx_cycle[2:0] <= epoch[2:0]);
        rx_cycle <= rx_cycle + 1;
        pop      <= i_rst_n && want;
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_word(input logic [63:0] w);
        i_block_word <= w;
        push         <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_word(w);
        burst_left--;
        if (burst_left <= 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    // Alpha halves give no texels, so a few extra cycles cover one still in flight.
    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_format(input t_format m);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_format(m);
    endtask

    // Now and then the two endpoints or the two alphas are made equal.
    function automatic logic [63:0] random_word();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        case ($urandom_range(0, 7))
            0: w[15:8] = w[7:0];
            1: w[31:16] = w[15:0];
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        logic [47:0] idx_ramp;
        logic [63:0] color_ramp;
        t_format     m;
        int          done_items;
        int          blocks;
        int          pick;
        bit          paused;

        sb = new();
        for (int t = 0; t < TEXELS; t++)
            idx_ramp[3 * t +: 3] = 3'(t % 8);
        color_ramp = {32'hE4E4E4E4, 16'h0000, 16'hFFFF};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Four-color mode straight out of reset.
        push_word(64'h0);
        push_word('1);
        push_word(color_ramp);
        push_word({32'hE4E4E4E4, 16'hFFFF, 16'h0000});
        push_word({32'h1B1B1B1B, 16'hA5A5, 16'hA5A5});

        write_format(FMT_DXT3);
        push_word(64'hFEDCBA9876543210);
        push_word(color_ramp);
        push_word(64'h0);
        push_word('1);
        push_word('1);
        push_word(64'h0);

        write_format(FMT_DXT5);
        push_word({idx_ramp, 8'h00, 8'hFF});
        push_word(color_ramp);
        push_word({idx_ramp, 8'hFF, 8'h00});
        push_word(color_ramp);
        wait_drained();
        push_word({idx_ramp, 8'h80, 8'h80});
        push_word('1);
        // A format write between the halves makes the next word an alpha half again.
        push_word({idx_ramp, 8'h00, 8'hFF});
        write_format(FMT_DXT5);
        push_word({idx_ramp, 8'h10, 8'hF0});
        push_word({32'h4E4E4E4E, 16'h001F, 16'hF800});

        write_format(FMT_NONE);
        push_word('1);
        push_word(64'h0);
        write_format(FMT_DXT1);
        push_word({32'h9C9C9C9C, 16'h07E0, 16'hF81F});

        done_items = 0;
        paused     = 1'b0;
        while (done_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                m = FMT_DXT1;
            else if (pick < 6)
                m = FMT_DXT3;
            else if (pick < 9)
                m = FMT_DXT5;
            else
                m = FMT_NONE;
            write_format(m);
            blocks = $urandom_range(2, 12);
            for (int b = 0; b < blocks; b++) begin
                if (b == blocks / 2 && (!paused || $urandom_range(0, 2) == 0)) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if (m == FMT_DXT1 || m == FMT_NONE) begin
                    push_word(random_word());
                    if (m == FMT_DXT1) done_items++;
                end else begin
                    push_word(random_word());
                    push_word(random_word());
                    done_items += 2;
                end
            end
            // Sometimes an alpha half is left without its color half.
            if ((m == FMT_DXT3 || m == FMT_DXT5) && $urandom_range(0, 3) == 0) begin
                push_word(random_word());
                done_items++;
            end
        end

        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dxt_pkg.sv
hdl/dxt_queue.sv
hdl/dxt_front.sv
hdl/dxt_back.sv
hdl/dxt_block_decoder.sv
tb/sv/tb_dxt_block_decoder.sv
